// ===== src/lob_pkg.sv =====
// ----------------------------------------------------------------------------
// lob_pkg
// shared types and constants for the label overlay blend pipeline
// ----------------------------------------------------------------------------
package lob_pkg;

  // label field width on the port
  localparam int LABEL_W = 16;

  // golden-angle hue step as a 24-bit fraction of a turn
  localparam logic [22:0] HUE_STEP = 23'd6408326;

  // ramp 255*(0.05+0.95*t): (265*2^24 + 4845*g) / (5*2^26), half up
  localparam logic [36:0] RAMP_BIAS = 37'd265 << 24;
  localparam logic [12:0] RAMP_GAIN = 13'd4845;
  // x/5 as (x*1639)>>13, exact for x below 1280
  localparam logic [10:0] DIV5_MUL  = 11'd1639;

  localparam logic [7:0] CH_HI = 8'd255;
  localparam logic [7:0] CH_LO = 8'd13;

  // overlay modes
  localparam logic [1:0] MODE_RED     = 2'd0;
  localparam logic [1:0] MODE_LABEL8  = 2'd1;
  localparam logic [1:0] MODE_LABEL16 = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_ALPHA     = 2'd0;
  localparam logic [1:0] CFG_MODE      = 2'd1;
  localparam logic [1:0] CFG_FAN_EN    = 2'd2;
  localparam logic [1:0] CFG_FAN_THRSH = 2'd3;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // per-word sideband that travels beside the colour pipe
  typedef struct packed {
    logic [7:0] gray;
    logic       colour_sel;
    logic       red_sel;
  } side_t;

endpackage

// ===== src/lob_colour.sv =====
// ----------------------------------------------------------------------------
// lob_colour
// four-stage label to golden-angle hsv colour (s 0.95, v 1)
// ----------------------------------------------------------------------------
module lob_colour
  import lob_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [LABEL_W-1:0] label,
  output rgb_t               rgb
);

  // stage 1: hue fraction
  logic [23:0] hue_r, hue_nxt;
  // stage 2: sector and ramp position
  logic [2:0]  sec2_r;
  logic [24:0] pos_r, pos_nxt;
  logic [26:0] hp;
  // stage 3: ramp numerator quotient by 2^26
  logic [2:0]  sec3_r;
  logic [10:0] q_r, q_nxt;
  logic [36:0] ramp_sum;
  // stage 4: channels
  rgb_t        rgb_r, rgb_nxt;
  logic [21:0] div_prod;
  logic [7:0]  t;

  logic [38:0] hue_prod;

  assign hue_prod = 39'(label) * 39'(HUE_STEP);
  assign hue_nxt  = hue_prod[23:0];

  // hue * 6 by shift and add
  assign hp      = {1'b0, hue_r, 2'b00} + {2'b00, hue_r, 1'b0};
  assign pos_nxt = hp[24] ? (25'd1 << 24) - {1'b0, hp[23:0]} : {1'b0, hp[23:0]};

  assign ramp_sum = RAMP_BIAS + 37'(pos_r) * 37'(RAMP_GAIN);
  assign q_nxt    = ramp_sum[36:26];

  assign div_prod = 22'(q_r) * 22'(DIV5_MUL);
  assign t        = div_prod[20:13];

  always_comb begin
    case (sec3_r)
      3'd0:    rgb_nxt = '{r: CH_HI, g: t,     b: CH_LO};
      3'd1:    rgb_nxt = '{r: t,     g: CH_HI, b: CH_LO};
      3'd2:    rgb_nxt = '{r: CH_LO, g: CH_HI, b: t};
      3'd3:    rgb_nxt = '{r: CH_LO, g: t,     b: CH_HI};
      3'd4:    rgb_nxt = '{r: t,     g: CH_LO, b: CH_HI};
      default: rgb_nxt = '{r: CH_HI, g: CH_LO, b: t};
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hue_r  <= hue_nxt;
      sec2_r <= hp[26:24];
      pos_r  <= pos_nxt;
      sec3_r <= sec2_r;
      q_r    <= q_nxt;
      rgb_r  <= rgb_nxt;
    end
  end

  assign rgb = rgb_r;

endmodule

// ===== src/label_overlay_blend.sv =====
// ----------------------------------------------------------------------------
// label_overlay_blend
// overlays a segmentation label colour on a gray sonar pixel, alpha blended
// ----------------------------------------------------------------------------
//  channel | ports                                      | handshake
//  --------+--------------------------------------------+------------------
//  in      | in_sonar_level, in_label_id, in_mask_hit   | in_valid/in_stall
//  out     | out_blue, out_green, out_red               | out_valid/out_stall
//  cfg     | cfg_addr, cfg_wdata                        | cfg_we
//
//  one word per clock unless out_stall holds the pipe, through four colour
//  stages and a blend stage; the rate is set by the pipe, nothing iterates
//  synchronous active-low reset clears valid bits and loads register defaults
//  the whole pipe holds while the output word is valid and stalled, so
//  in_stall follows out_stall only then
// ----------------------------------------------------------------------------
module label_overlay_blend
  import lob_pkg::*;
#(
  parameter int LABEL_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // input words
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_sonar_level,
  input  logic [LABEL_W-1:0] in_label_id,
  input  logic               in_mask_hit,
  // result words
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_blue,
  output logic [7:0]         out_green,
  output logic [7:0]         out_red,
  // register writes
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [8:0]         cfg_wdata
);

  localparam int NSTG = 4;
  localparam logic [LABEL_W-1:0] LabelMask = LABEL_W'((32'd1 << LABEL_BITS) - 1);

  // configuration registers
  logic [8:0] alpha_r;
  logic [1:0] mode_r;
  logic       fan_en_r;
  logic [7:0] fan_thr_r;

  // pipe control
  logic        en;
  logic        vld_r [NSTG];
  side_t       side_r [NSTG];
  side_t       side_in;
  logic [LABEL_W-1:0] lab;
  logic        colour_mode;
  rgb_t        col_rgb;

  // blend stage
  logic [8:0]  a_sat;
  rgb_t        ov;
  logic        fan_gray;
  rgb_t        res_nxt, res_r;
  logic        out_vld_r;

  // advance whenever the output word is empty or taken
  assign en       = !out_vld_r || !out_stall;
  assign in_stall = !en;

  // -- register port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r   <= 9'd166;
      mode_r    <= MODE_RED;
      fan_en_r  <= 1'b1;
      fan_thr_r <= 8'd5;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_ALPHA:     alpha_r   <= cfg_wdata;
        CFG_MODE:      mode_r    <= cfg_wdata[1:0];
        CFG_FAN_EN:    fan_en_r  <= cfg_wdata[0];
        CFG_FAN_THRSH: fan_thr_r <= cfg_wdata[7:0];
        default:       ;
      endcase
    end
  end

  // -- overlay selection on entry
  // mode three has no meaning and falls back to the red mask
  assign colour_mode = (mode_r == MODE_LABEL8) || (mode_r == MODE_LABEL16);
  assign lab = (mode_r == MODE_LABEL8) ? {{(LABEL_W-8){1'b0}}, in_label_id[7:0]}
                                       : (in_label_id & LabelMask);

  always_comb begin
    side_in.gray       = in_sonar_level;
    side_in.colour_sel = colour_mode && (lab != '0);
    side_in.red_sel    = !colour_mode && in_mask_hit;
  end

  // -- colour pipe, four stages
  lob_colour u_colour (
    .clk   (clk),
    .en    (en),
    .label (lab),
    .rgb   (col_rgb)
  );

  // sideband shift line aligned with the colour stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSTG; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < NSTG; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_in;
      for (int i = 1; i < NSTG; i++) side_r[i] <= side_r[i-1];
    end
  end

  // -- blend stage
  function automatic logic [7:0] blend_ch(input logic [7:0] o, input logic [7:0] gy,
                                          input logic [8:0] a);
    logic [16:0] acc;
    acc = 17'(a) * 17'(o) + 17'(9'd256 - a) * 17'(gy) + 17'd128;
    return (acc[16:8] > 9'd255) ? 8'd255 : acc[15:8];
  endfunction

  // alpha above unity clamps to unity
  assign a_sat = alpha_r[8] ? 9'd256 : alpha_r;

  always_comb begin
    if (side_r[NSTG-1].colour_sel) begin
      ov = col_rgb;
    end else if (side_r[NSTG-1].red_sel) begin
      ov = '{r: 8'd255, g: 8'd0, b: 8'd0};
    end else begin
      ov = '{r: side_r[NSTG-1].gray, g: side_r[NSTG-1].gray, b: side_r[NSTG-1].gray};
    end
  end

  // with fan gating enabled, a pixel outside the sonar fan (gray at or below the threshold) stays plain gray
  assign fan_gray = fan_en_r && (side_r[NSTG-1].gray <= fan_thr_r);

  always_comb begin
    if (fan_gray) begin
      res_nxt = '{r: side_r[NSTG-1].gray, g: side_r[NSTG-1].gray,
                  b: side_r[NSTG-1].gray};
    end else begin
      res_nxt.r = blend_ch(ov.r, side_r[NSTG-1].gray, a_sat);
      res_nxt.g = blend_ch(ov.g, side_r[NSTG-1].gray, a_sat);
      res_nxt.b = blend_ch(ov.b, side_r[NSTG-1].gray, a_sat);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_red   = res_r.r;
  assign out_green = res_r.g;
  assign out_blue  = res_r.b;

  // -- checks
  // a label colour always has one full channel and no channel below the floor
  a_colour_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NSTG-1] && side_r[NSTG-1].colour_sel |->
      (col_rgb.r == CH_HI || col_rgb.g == CH_HI || col_rgb.b == CH_HI) &&
      col_rgb.r >= CH_LO && col_rgb.g >= CH_LO && col_rgb.b >= CH_LO)
    else $error("label colour out of range");

  // a stalled result freezes the last pipe stage too
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_stall |=> $stable(side_r[NSTG-1]) && $stable(vld_r[NSTG-1]))
    else $error("pipe moved under output stall");

  // a taken result with an empty stage behind it leaves the output empty
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_stall && !vld_r[NSTG-1] |=> !out_vld_r)
    else $error("result word repeated");

endmodule
